// File: hdl/span_future_score_dp_unit_macros.svh
// Assertion macros for the span score table unit.
`ifndef SPAN_FUTURE_SCORE_DP_UNIT_MACROS_SVH
`define SPAN_FUTURE_SCORE_DP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SFSDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfsdp: assertion failed");

// next-cycle implication, disabled during reset
`define SFSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfsdp: assertion failed");

`else

`define SFSDP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/sfsdp_pkg.sv
// Types and constants shared by the span score table unit.
package sfsdp_pkg;

    localparam int SCORE_W = 32;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // most negative code stands for minus infinity
    localparam logic signed [SCORE_W-1:0] NEG_INF   = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        logic [1:0]                op;
        logic [5:0]                span_start;
        logic [5:0]                span_end;
        logic signed [SCORE_W-1:0] option_score;
        logic [6:0]                sentence_length;
    } req_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] cell_score;
        logic                      cell_reachable;
        logic                      range_error;
    } rsp_t;

endpackage

// File: hdl/sfsdp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module sfsdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hdl/span_future_score_dp_unit.sv
// Span score table unit: clear the table, add/read cells, and fill best split sums over the table.
// Read/add: cell read, then S_UPDATE; bad span: answered from idle; clear: sweeps every cell.
// Compute: per cell of span length len >= 1, S_CUR reads it, S_SPLIT issues one split per cycle
// from a dual-read RAM to the single shared add/compare unit, S_FINISH and S_WRITE store the best.
// One word in flight; req_stall is high from accept until the result is formed and while it
// waits under rsp_stall; reads and adds end before the next word, bad spans one a cycle while rsp_stall low.
// Reset: word count one and a clear-length sweep of minus infinity, req_stall high, no result.
`include "span_future_score_dp_unit_macros.svh"

module span_future_score_dp_unit #(
    parameter int MAX_WORDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sfsdp_pkg::req_t   req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sfsdp_pkg::rsp_t   rsp_word
);

    localparam int IW    = $clog2(MAX_WORDS);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int XW    = CW + 1;
    localparam int CMPW  = (CW > 6) ? CW : 6;
    localparam int SW    = sfsdp_pkg::SCORE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_CUR    = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_UPDATE = 3'd6;

    function automatic logic signed [SW-1:0] sat_join(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b
    );
        logic signed [SW:0] sum;
        sum = $signed({a[SW-1], a}) + $signed({b[SW-1], b});
        if (a == sfsdp_pkg::NEG_INF || b == sfsdp_pkg::NEG_INF)
        begin
            return sfsdp_pkg::NEG_INF;
        end
        if (sum > $signed({1'b0, sfsdp_pkg::SCORE_MAX}))
        begin
            return sfsdp_pkg::SCORE_MAX;
        end
        if (sum <= $signed({1'b1, sfsdp_pkg::NEG_INF}))
        begin
            return sfsdp_pkg::NEG_INF;
        end
        return sum[SW-1:0];
    endfunction

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] word_count_reg, word_count_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          sweep_rsp_reg, sweep_rsp_next;
    logic [IW-1:0] s_reg, s_next;
    logic [IW-1:0] len_reg, len_next;
    logic [IW-1:0] j_reg, j_next;
    logic          load_cur_reg, load_cur_next;
    logic          split_vld_reg, split_vld_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    logic signed [SW-1:0] best_reg, best_next;
    logic signed [SW-1:0] score_reg, score_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [1:0]           op_reg, op_next;
    sfsdp_pkg::rsp_t      rsp_reg, rsp_next;

    logic                 produce;
    logic                 accept;
    logic                 bad_span;
    logic [IW-1:0]        in_s, in_e, e_cell, j_inc;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [SW-1:0]        ram_wdata, ram_rdata_a, ram_rdata_b;
    logic signed [SW-1:0] rd_a, rd_b, joined;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    assign in_s     = IW'(req_word.span_start);
    assign in_e     = IW'(req_word.span_end);
    assign bad_span = (req_word.span_end < req_word.span_start)
                   || (CMPW'(req_word.span_end) >= CMPW'(word_count_reg));

    assign e_cell = s_reg + len_reg;
    assign j_inc  = j_reg + 1'b1;
    assign rd_a   = $signed(ram_rdata_a);
    assign rd_b   = $signed(ram_rdata_b);
    assign joined = sat_join(rd_a, rd_b);

    sfsdp_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        sweep_next      = sweep_reg;
        sweep_rsp_next  = sweep_rsp_reg;
        s_next          = s_reg;
        len_next        = len_reg;
        j_next          = j_reg;
        load_cur_next   = 1'b0;
        split_vld_next  = 1'b0;
        best_next       = best_reg;
        score_next      = score_reg;
        addr_next       = addr_reg;
        op_next         = op_reg;
        produce         = 1'b0;
        rsp_next        = '0;
        ram_we          = 1'b0;
        ram_waddr       = {s_reg, e_cell};
        ram_wdata       = best_reg;
        ram_raddr_a     = {in_s, in_e};
        ram_raddr_b     = {j_inc, e_cell};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req_word.op;
                    score_next = req_word.option_score;
                    addr_next  = {in_s, in_e};
                    unique case (req_word.op) inside
                        sfsdp_pkg::OP_CLEAR:
                        begin
                            if (req_word.sentence_length == 7'd0)
                            begin
                                word_count_next = CW'(1);
                            end
                            else if (int'(req_word.sentence_length) > MAX_WORDS)
                            begin
                                word_count_next = CW'(MAX_WORDS);
                            end
                            else
                            begin
                                word_count_next = CW'(req_word.sentence_length);
                            end
                            sweep_next     = '0;
                            sweep_rsp_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        sfsdp_pkg::OP_COMPUTE:
                        begin
                            if (word_count_reg < CW'(2))
                            begin
                                produce = 1'b1;
                            end
                            else
                            begin
                                s_next     = '0;
                                len_next   = IW'(1);
                                state_next = S_CUR;
                            end
                        end
                        sfsdp_pkg::OP_ADD, sfsdp_pkg::OP_READ:
                        begin
                            if (bad_span)
                            begin
                                produce              = 1'b1;
                                rsp_next.range_error = 1'b1;
                            end
                            else
                            begin
                                // cell read issued here, data back in S_UPDATE
                                state_next = S_UPDATE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = sfsdp_pkg::NEG_INF;
                if (sweep_reg == {AW{1'b1}})
                begin
                    produce    = sweep_rsp_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_CUR:
            begin
                ram_raddr_a   = {s_reg, e_cell};
                load_cur_next = 1'b1;
                j_next        = s_reg;
                state_next    = S_SPLIT;
            end
            S_SPLIT, S_FINISH:
            begin
                if (load_cur_reg)
                begin
                    best_next = rd_a;
                end
                else if (split_vld_reg && (joined > best_reg))
                begin
                    best_next = joined;
                end
                if (state_reg == S_SPLIT)
                begin
                    // issue split j: left (s, j), right (j+1, e)
                    ram_raddr_a    = {s_reg, j_reg};
                    split_vld_next = 1'b1;
                    if (j_reg == e_cell - 1'b1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        j_next = j_inc;
                    end
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                if ((XW'(e_cell) + XW'(1)) < XW'(word_count_reg))
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_CUR;
                end
                else if ((XW'(len_reg) + XW'(1)) < XW'(word_count_reg))
                begin
                    s_next     = '0;
                    len_next   = len_reg + 1'b1;
                    state_next = S_CUR;
                end
                else
                begin
                    produce    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                produce    = 1'b1;
                state_next = S_IDLE;
                ram_waddr  = addr_reg;
                ram_wdata  = score_reg;
                if (op_reg == sfsdp_pkg::OP_ADD)
                begin
                    ram_we = score_reg > rd_a;
                end
                else
                begin
                    rsp_next.cell_score     = rd_a;
                    rsp_next.cell_reachable = (rd_a != sfsdp_pkg::NEG_INF);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (produce)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            word_count_reg <= CW'(1);
            sweep_reg      <= '0;
            sweep_rsp_reg  <= 1'b0;
            s_reg          <= '0;
            len_reg        <= '0;
            j_reg          <= '0;
            load_cur_reg   <= 1'b0;
            split_vld_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            sweep_reg      <= sweep_next;
            sweep_rsp_reg  <= sweep_rsp_next;
            s_reg          <= s_next;
            len_reg        <= len_next;
            j_reg          <= j_next;
            load_cur_reg   <= load_cur_next;
            split_vld_reg  <= split_vld_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        score_reg <= score_next;
        addr_reg  <= addr_next;
        op_reg    <= op_next;
        if (produce)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `SFSDP_ASSERT_IMP(a_no_overwrite_pending, clk, rst_n, produce,
                      !(rsp_valid_reg && rsp_stall))
    `SFSDP_ASSERT_IMP(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !ram_we)
    `SFSDP_ASSERT_IMP(a_split_in_span, clk, rst_n, state_reg == S_SPLIT,
                      (j_reg >= s_reg) && (j_reg < e_cell))
    `SFSDP_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1,
                      (word_count_reg != '0) && (int'(word_count_reg) <= MAX_WORDS))
    `SFSDP_ASSERT_NEXT(a_clear_sweeps, clk, rst_n,
                       accept && (req_word.op == sfsdp_pkg::OP_CLEAR),
                       (state_reg == S_SWEEP) && (sweep_reg == '0))

endmodule

// File: tb/sv/tb_span_future_score_dp_unit.sv
// Testbench for the span score table unit: directed and random sentences checked by a predictor.
module tb_span_future_score_dp_unit;

    localparam int MAX_WORDS = 64;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sfsdp_pkg::req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sfsdp_pkg::rsp_t rsp_word;

    span_future_score_dp_unit #(
        .MAX_WORDS(MAX_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // predictor state
    logic signed [sfsdp_pkg::SCORE_W-1:0] best_score [0:MAX_WORDS-1][0:MAX_WORDS-1];
    int   word_total;
    sfsdp_pkg::rsp_t expected_cells [$];

    int tx_idle_pct = 34;
    int rx_idle_pct = 56;

    int n_items, n_good, n_clear, n_compute, n_reach, n_range_err;
    int n_checked, fail_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic logic signed [sfsdp_pkg::SCORE_W-1:0] join_scores(
        input logic signed [sfsdp_pkg::SCORE_W-1:0] a,
        input logic signed [sfsdp_pkg::SCORE_W-1:0] b
    );
        logic signed [sfsdp_pkg::SCORE_W:0] total;
        if (a == sfsdp_pkg::NEG_INF || b == sfsdp_pkg::NEG_INF)
            return sfsdp_pkg::NEG_INF;
        total = {a[sfsdp_pkg::SCORE_W-1], a} + {b[sfsdp_pkg::SCORE_W-1], b};
        if (total > $signed({1'b0, sfsdp_pkg::SCORE_MAX}))
            return sfsdp_pkg::SCORE_MAX;
        // hitting the most negative code means minus infinity as well
        if (total <= $signed({1'b1, sfsdp_pkg::NEG_INF}))
            return sfsdp_pkg::NEG_INF;
        return total[sfsdp_pkg::SCORE_W-1:0];
    endfunction

    function automatic void fill_best_splits();
        logic signed [sfsdp_pkg::SCORE_W-1:0] joined;
        for (int len = 1; len < word_total; len++)
            for (int s = 0; s + len < word_total; s++)
                for (int j = s; j < s + len; j++)
                begin
                    joined = join_scores(best_score[s][j], best_score[j+1][s+len]);
                    if (joined > best_score[s][s+len])
                        best_score[s][s+len] = joined;
                end
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < MAX_WORDS; s++)
            for (int e = 0; e < MAX_WORDS; e++)
                best_score[s][e] = sfsdp_pkg::NEG_INF;
    endfunction

    // works out the result word for one accepted request word
    function automatic void model_word(input sfsdp_pkg::req_t w);
        sfsdp_pkg::rsp_t r;
        int n;
        logic signed [sfsdp_pkg::SCORE_W-1:0] offer;
        r = '0;
        offer = w.option_score;
        n_items++;
        case (w.op)
            sfsdp_pkg::OP_CLEAR:
            begin
                n = w.sentence_length;
                if (n == 0)
                    n = 1;
                if (n > MAX_WORDS)
                    n = MAX_WORDS;
                word_total = n;
                clear_table();
                n_clear++;
            end
            sfsdp_pkg::OP_COMPUTE:
            begin
                fill_best_splits();
                n_compute++;
            end
            default:
            begin
                if (w.span_end < w.span_start || w.span_end >= word_total)
                    r.range_error = 1'b1;
                else if (w.op == sfsdp_pkg::OP_ADD)
                begin
                    if (offer > best_score[w.span_start][w.span_end])
                        best_score[w.span_start][w.span_end] = offer;
                end
                else
                begin
                    r.cell_score     = best_score[w.span_start][w.span_end];
                    r.cell_reachable = (r.cell_score != sfsdp_pkg::NEG_INF);
                    if (r.cell_reachable)
                        n_reach++;
                end
            end
        endcase
        if (r.range_error)
            n_range_err++;
        else
            n_good++;
        expected_cells = {expected_cells, r};
    endfunction

    task automatic send_word(input sfsdp_pkg::req_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        model_word(w);
    endtask

    // fields that the operation does not use stay random
    task automatic issue(input logic [1:0] op, input int s, input int e,
                         input logic signed [sfsdp_pkg::SCORE_W-1:0] score,
                         input int len);
        logic [63:0] bits;
        sfsdp_pkg::req_t w;
        bits = {$urandom, $urandom};
        w = bits[$bits(sfsdp_pkg::req_t)-1:0];
        w.op = op;
        case (op)
            sfsdp_pkg::OP_CLEAR:
                w.sentence_length = 7'(len);
            sfsdp_pkg::OP_ADD:
            begin
                w.span_start   = 6'(s);
                w.span_end     = 6'(e);
                w.option_score = score;
            end
            sfsdp_pkg::OP_READ:
            begin
                w.span_start = 6'(s);
                w.span_end   = 6'(e);
            end
            default: ;
        endcase
        send_word(w);
    endtask

    function automatic logic signed [sfsdp_pkg::SCORE_W-1:0] pick_score();
        logic signed [sfsdp_pkg::SCORE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v = sfsdp_pkg::NEG_INF;
            1:       v = sfsdp_pkg::SCORE_MAX - $urandom_range(0, 3);
            2:       v = sfsdp_pkg::NEG_INF + $urandom_range(1, 3);
            3, 4:    ;
            default: v = v >>> 9;
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        sfsdp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t: result word with none pending: actual %h", $time, rsp_word);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                n_checked++;
                if (rsp_word.cell_score !== want.cell_score)
                begin
                    $display("%0t: cell_score expected %h actual %h",
                             $time, want.cell_score, rsp_word.cell_score);
                    fail_count++;
                end
                if (rsp_word.cell_reachable !== want.cell_reachable)
                begin
                    $display("%0t: cell_reachable expected %b actual %b",
                             $time, want.cell_reachable, rsp_word.cell_reachable);
                    fail_count++;
                end
                if (rsp_word.range_error !== want.range_error)
                begin
                    $display("%0t: range_error expected %b actual %b",
                             $time, want.range_error, rsp_word.range_error);
                    fail_count++;
                end
            end
        end
    end

    // table after the reset sweep, bad span on a one-word sentence, zero length clamp
    task automatic test_after_reset();
        issue(sfsdp_pkg::OP_READ, 0, 0, '0, 0);
        issue(sfsdp_pkg::OP_READ, 0, 1, '0, 0);
        issue(sfsdp_pkg::OP_ADD, 0, 0, sfsdp_pkg::SCORE_MAX, 0);
        issue(sfsdp_pkg::OP_READ, 0, 0, '0, 0);
        issue(sfsdp_pkg::OP_CLEAR, 0, 0, '0, 0);
        issue(sfsdp_pkg::OP_READ, 0, 0, '0, 0);
    endtask

    // full-size sentence: keep-max, both saturations, a word with no option
    task automatic test_table_fill();
        issue(sfsdp_pkg::OP_CLEAR, 0, 0, '0, 127);
        issue(sfsdp_pkg::OP_ADD, 0, 0, 32'sd5 <<< 16, 0);
        issue(sfsdp_pkg::OP_ADD, 0, 0, 32'sd3 <<< 16, 0);
        issue(sfsdp_pkg::OP_ADD, 1, 1, sfsdp_pkg::SCORE_MAX, 0);
        issue(sfsdp_pkg::OP_ADD, 2, 2, sfsdp_pkg::SCORE_MAX, 0);
        issue(sfsdp_pkg::OP_ADD, 3, 3, sfsdp_pkg::NEG_INF + 1, 0);
        issue(sfsdp_pkg::OP_ADD, 4, 4, -32'sd1, 0);
        issue(sfsdp_pkg::OP_ADD, 6, 6, 32'sd1 <<< 16, 0);
        issue(sfsdp_pkg::OP_ADD, 63, 63, sfsdp_pkg::NEG_INF, 0);
        issue(sfsdp_pkg::OP_ADD, 5, 4, 32'sd7, 0);
        issue(sfsdp_pkg::OP_COMPUTE, 0, 0, '0, 0);
        issue(sfsdp_pkg::OP_READ, 0, 1, '0, 0);
        issue(sfsdp_pkg::OP_READ, 1, 2, '0, 0);
        issue(sfsdp_pkg::OP_READ, 3, 4, '0, 0);
        issue(sfsdp_pkg::OP_READ, 0, 4, '0, 0);
        issue(sfsdp_pkg::OP_READ, 6, 6, '0, 0);
        issue(sfsdp_pkg::OP_READ, 4, 6, '0, 0);
        issue(sfsdp_pkg::OP_READ, 0, 63, '0, 0);
        issue(sfsdp_pkg::OP_READ, 7, 6, '0, 0);
    endtask

    // random spans that may fall outside the sentence
    task automatic send_noise();
        issue($urandom_range(0, 1) ? sfsdp_pkg::OP_ADD : sfsdp_pkg::OP_READ,
              $urandom_range(0, 63), $urandom_range(0, 63), pick_score(), 0);
    endtask

    task automatic read_some(input int count);
        int s;
        repeat (count)
        begin
            s = $urandom_range(0, word_total - 1);
            if ($urandom_range(0, 4) == 0)
                issue(sfsdp_pkg::OP_READ, 0, word_total - 1, '0, 0);
            else
                issue(sfsdp_pkg::OP_READ, s, $urandom_range(s, word_total - 1), '0, 0);
        end
    endtask

    task automatic add_some(input int count);
        int s;
        repeat (count)
        begin
            s = $urandom_range(0, word_total - 1);
            issue(sfsdp_pkg::OP_ADD, s, $urandom_range(s, word_total - 1), pick_score(), 0);
        end
    endtask

    // whole sentences with random content; one full-size sentence per phase
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target);
        int goal, sentence, len, pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = n_good + target;
        sentence = 0;
        while (n_good < goal)
        begin
            pick = $urandom_range(0, 19);
            if (sentence == 2)
                len = $urandom_range(MAX_WORDS, 127);
            else if (pick == 0)
                len = 0;
            else if (pick < 3)
                len = $urandom_range(13, 24);
            else
                len = $urandom_range(1, 12);
            issue(sfsdp_pkg::OP_CLEAR, 0, 0, '0, len);
            for (int w = 0; w < word_total; w++)
                if ($urandom_range(0, 9) < 8)
                    issue(sfsdp_pkg::OP_ADD, w, w, pick_score(), 0);
            add_some($urandom_range(0, word_total));
            repeat ($urandom_range(0, 3))
                send_noise();
            issue(sfsdp_pkg::OP_COMPUTE, 0, 0, '0, 0);
            read_some($urandom_range(5, 20));
            if ($urandom_range(0, 2) == 0)
            begin
                add_some($urandom_range(1, 4));
                issue(sfsdp_pkg::OP_COMPUTE, 0, 0, '0, 0);
                read_some($urandom_range(3, 10));
            end
            repeat ($urandom_range(0, 2))
                send_noise();
            sentence++;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        word_total = 1;
        clear_table();
        test_after_reset();
        test_table_fill();
        test_random_traffic(34, 56, 500);
        test_random_traffic(56, 34, 500);
        test_random_traffic(0, 0, 500);
        req_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("run covered %0d words: %0d clears, %0d computes, %0d reachable reads",
                 n_items, n_clear, n_compute, n_reach);
        $display("%0d span errors, %0d result words checked, %0d mismatches",
                 n_range_err, n_checked, fail_count);
        if (fail_count == 0)
            $display("span_future_score_dp_unit verification clean");
        else
            $display("span_future_score_dp_unit verification failed");
        $finish;
    end

    // several times the slowest expected run, clear sweeps and full-size fills included
    initial
    begin
        #60000000;
        $display("span_future_score_dp_unit verification failed");
        $finish;
    end

endmodule
